// ----- design/first_fit_free_list_allocator_assert.svh -----
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define FFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define FFA_NEVER(lbl, clk, rstn, cond, msg) \
  `FFA_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ----- design/ffa_pkg.sv -----
// Shared codes and controller/datapath interface types of the allocator.
package ffa_pkg;

  localparam int unsigned HEADER_BYTES = 8;

  localparam logic [2:0] ST_REUSED  = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_ZERO    = 3'd2;
  localparam logic [2:0] ST_OOM     = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;
  localparam logic [2:0] ST_NULL    = 3'd5;
  localparam logic [2:0] ST_UNKNOWN = 3'd6;
  localparam logic [2:0] ST_FULL    = 3'd7;

  typedef struct packed {
    logic       load;
    logic       ptr_top;
    logic       ptr_clr;
    logic       ptr_dec;
    logic       ptr_inc;
    logic       fo_rd;
    logic       fo_rd_next;
    logic       blk_rd;
    logic       blk_rd_idx;
    logic       take;
    logic       shift_wr;
    logic       fc_dec;
    logic       push;
    logic       bump_new;
    logic       res_we;
    logic       res_reused;
    logic [2:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic is_free_op;
    logic req_zero;
    logic addr_null;
    logic fc_zero;
    logic bc_zero;
    logic ptr_zero;
    logic fits;
    logic more_after_ptr;
    logic more_after_next;
    logic match;
    logic reject_free;
    logic lookup_last;
    logic oom;
    logic full;
  } sts_t;

endpackage

// ----- design/ffa_ctrl.sv -----
// Sequencer of the allocator: steps the free-list scan, list shifting and table lookup.
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ffa_pkg::sts_t sts_i,
  output ffa_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_AFO  = 4'd2;
  localparam logic [3:0] S_ASZ  = 4'd3;
  localparam logic [3:0] S_ACMP = 4'd4;
  localparam logic [3:0] S_SHRD = 4'd5;
  localparam logic [3:0] S_SHWR = 4'd6;
  localparam logic [3:0] S_BUMP = 4'd7;
  localparam logic [3:0] S_LRD  = 4'd8;
  localparam logic [3:0] S_LCMP = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts_i.is_free_op) begin
          if (sts_i.req_zero) begin
            cmd_o.res_we     = 1'b1;
            cmd_o.res_status = ffa_pkg::ST_ZERO;
            state_d          = S_IDLE;
          end else if (sts_i.fc_zero) begin
            state_d = S_BUMP;
          end else begin
            // The list is kept with its front at the highest slot.
            cmd_o.ptr_top = 1'b1;
            state_d       = S_AFO;
          end
        end else begin
          if (sts_i.addr_null) begin
            cmd_o.res_we     = 1'b1;
            cmd_o.res_status = ffa_pkg::ST_NULL;
            state_d          = S_IDLE;
          end else if (sts_i.bc_zero) begin
            cmd_o.res_we     = 1'b1;
            cmd_o.res_status = ffa_pkg::ST_UNKNOWN;
            state_d          = S_IDLE;
          end else begin
            cmd_o.ptr_clr = 1'b1;
            state_d       = S_LRD;
          end
        end
      end
      S_AFO: begin
        cmd_o.fo_rd = 1'b1;
        state_d     = S_ASZ;
      end
      S_ASZ: begin
        cmd_o.blk_rd     = 1'b1;
        cmd_o.blk_rd_idx = 1'b1;
        state_d          = S_ACMP;
      end
      S_ACMP: begin
        if (sts_i.fits) begin
          cmd_o.take       = 1'b1;
          cmd_o.res_we     = 1'b1;
          cmd_o.res_reused = 1'b1;
          cmd_o.res_status = ffa_pkg::ST_REUSED;
          if (sts_i.more_after_ptr) begin
            state_d = S_SHRD;
          end else begin
            cmd_o.fc_dec = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (sts_i.ptr_zero) begin
          state_d = S_BUMP;
        end else begin
          cmd_o.ptr_dec = 1'b1;
          state_d       = S_AFO;
        end
      end
      S_SHRD: begin
        cmd_o.fo_rd      = 1'b1;
        cmd_o.fo_rd_next = 1'b1;
        state_d          = S_SHWR;
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        if (sts_i.more_after_next) begin
          state_d = S_SHRD;
        end else begin
          cmd_o.fc_dec = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_BUMP: begin
        cmd_o.res_we = 1'b1;
        if (sts_i.oom) begin
          cmd_o.res_status = ffa_pkg::ST_OOM;
        end else if (sts_i.full) begin
          cmd_o.res_status = ffa_pkg::ST_FULL;
        end else begin
          cmd_o.bump_new   = 1'b1;
          cmd_o.res_status = ffa_pkg::ST_NEW;
        end
        state_d = S_IDLE;
      end
      S_LRD: begin
        cmd_o.blk_rd = 1'b1;
        state_d      = S_LCMP;
      end
      S_LCMP: begin
        if (sts_i.match) begin
          cmd_o.res_we = 1'b1;
          if (sts_i.reject_free) begin
            cmd_o.res_status = ffa_pkg::ST_UNKNOWN;
          end else begin
            cmd_o.push       = 1'b1;
            cmd_o.res_status = ffa_pkg::ST_FREED;
          end
          state_d = S_IDLE;
        end else if (sts_i.lookup_last) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ffa_pkg::ST_UNKNOWN;
          state_d          = S_IDLE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_LRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cmd_o.res_we) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/ffa_dpath.sv -----
// Datapath of the allocator: block table, free list memory, counters and result register.
module ffa_dpath #(
  parameter int unsigned HEAP_BYTES = 1048576,
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          opcode_i,
  input  logic [31:0]   request_size_i,
  input  logic [31:0]   block_address_i,
  input  ffa_pkg::cmd_t cmd_i,
  output ffa_pkg::sts_t sts_o,
  output logic [31:0]   result_address_o,
  output logic [2:0]    status_o
);

  localparam int unsigned OFS_W = $clog2(HEAP_BYTES + 1);
  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned P_W   = CNT_W + 1;

  logic [OFS_W-1:0] off_mem  [MAX_BLOCKS];
  logic [OFS_W-1:0] size_mem [MAX_BLOCKS];
  logic [IDX_W-1:0] fo_mem   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] is_free_q;

  logic [31:0]      kend_q;
  logic             op_q;
  logic [32:0]      size_q;
  logic [31:0]      addr_q;
  logic [IDX_W-1:0] ptr_q;
  logic [CNT_W-1:0] bc_q, fc_q;
  logic [OFS_W-1:0] bump_q;
  logic [IDX_W-1:0] fo_rd_q;
  logic [OFS_W-1:0] off_rd_q, size_rd_q;
  logic [31:0]      res_addr_q;
  logic [2:0]       res_status_q;

  logic [31:0]      base;
  logic [31:0]      tgt;
  logic [P_W-1:0]   ptr_p1, ptr_p2;
  logic [33:0]      bump_end;
  logic [IDX_W-1:0] fo_raddr, blk_raddr, fo_waddr, fo_wdata;
  logic [IDX_W-1:0] bc_idx;

  assign base     = (kend_q + 32'd3) & ~32'd3;
  assign tgt      = addr_q - base - 32'(ffa_pkg::HEADER_BYTES);
  assign ptr_p1   = P_W'(ptr_q) + P_W'(1);
  assign ptr_p2   = P_W'(ptr_q) + P_W'(2);
  assign bump_end = 34'(bump_q) + 34'(ffa_pkg::HEADER_BYTES) + 34'(size_q);
  assign bc_idx   = bc_q[IDX_W-1:0];

  assign fo_raddr  = cmd_i.fo_rd_next ? IDX_W'(ptr_p1) : ptr_q;
  assign blk_raddr = cmd_i.blk_rd_idx ? fo_rd_q : ptr_q;
  assign fo_waddr  = cmd_i.push ? fc_q[IDX_W-1:0] : ptr_q;
  assign fo_wdata  = cmd_i.push ? ptr_q : fo_rd_q;

  always_comb begin
    sts_o.is_free_op      = op_q;
    sts_o.req_zero        = (size_q == 33'd0);
    sts_o.addr_null       = (addr_q == 32'd0);
    sts_o.fc_zero         = (fc_q == '0);
    sts_o.bc_zero         = (bc_q == '0);
    sts_o.ptr_zero        = (ptr_q == '0);
    sts_o.fits            = (33'(size_rd_q) >= size_q);
    sts_o.more_after_ptr  = (ptr_p1 < P_W'(fc_q));
    sts_o.more_after_next = (ptr_p2 < P_W'(fc_q));
    sts_o.match           = (tgt[31:OFS_W] == '0) && (tgt[OFS_W-1:0] == off_rd_q);
    sts_o.reject_free     = is_free_q[ptr_q] || (fc_q == CNT_W'(MAX_BLOCKS));
    sts_o.lookup_last     = (ptr_p1 >= P_W'(bc_q));
    sts_o.oom             = (bump_end > 34'(HEAP_BYTES));
    sts_o.full            = (bc_q == CNT_W'(MAX_BLOCKS));
  end

  // Memories: one write and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fo_rd) begin
      fo_rd_q <= fo_mem[fo_raddr];
    end
    if (cmd_i.shift_wr || cmd_i.push) begin
      fo_mem[fo_waddr] <= fo_wdata;
    end
    if (cmd_i.blk_rd) begin
      off_rd_q  <= off_mem[blk_raddr];
      size_rd_q <= size_mem[blk_raddr];
    end
    if (cmd_i.bump_new) begin
      off_mem[bc_idx]  <= bump_q;
      size_mem[bc_idx] <= size_q[OFS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      // A zero request stays zero; rounding is carried in 33 bits.
      size_q <= (33'(request_size_i) + 33'd3) & ~33'd3;
      addr_q <= block_address_i;
    end
    if (cmd_i.res_we) begin
      res_status_q <= cmd_i.res_status;
      if (cmd_i.res_reused) begin
        res_addr_q <= base + 32'(off_rd_q) + 32'(ffa_pkg::HEADER_BYTES);
      end else if (cmd_i.bump_new) begin
        res_addr_q <= base + 32'(bump_q) + 32'(ffa_pkg::HEADER_BYTES);
      end else begin
        res_addr_q <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kend_q    <= 32'd0;
      ptr_q     <= '0;
      bc_q      <= '0;
      fc_q      <= '0;
      bump_q    <= '0;
      is_free_q <= '0;
    end else begin
      if (cfg_we_i) begin
        kend_q <= cfg_wdata_i;
      end
      if (cmd_i.ptr_top) begin
        ptr_q <= IDX_W'(fc_q - CNT_W'(1));
      end else if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_q - IDX_W'(1);
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= IDX_W'(ptr_p1);
      end
      if (cmd_i.take) begin
        is_free_q[fo_rd_q] <= 1'b0;
      end
      if (cmd_i.fc_dec) begin
        fc_q <= fc_q - CNT_W'(1);
      end
      if (cmd_i.push) begin
        is_free_q[ptr_q] <= 1'b1;
        fc_q             <= fc_q + CNT_W'(1);
      end
      if (cmd_i.bump_new) begin
        is_free_q[bc_idx] <= 1'b0;
        bc_q              <= bc_q + CNT_W'(1);
        bump_q            <= OFS_W'(bump_end);
      end
    end
  end

  assign result_address_o = res_addr_q;
  assign status_o         = res_status_q;

endmodule

// ----- design/first_fit_free_list_allocator.sv -----
// Zero-size, null and empty-table requests are answered from the dispatch state; an allocate
// with an empty free list goes to the bump step; otherwise an allocate reads and compares each
// free-list entry visited (bump step if none fits), and a free compares each block-table entry.
// Throughput: one item at a time; the next beat is taken once the result beat has left and any
// shift after a reuse is done.
// Reset (rst_ni, asynchronous): empty table and free list, bump pointer and base at zero.
module first_fit_free_list_allocator #(
  parameter int unsigned HEAP_BYTES = 1048576,
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] request_size_i,
  input  logic [31:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_address_o,
  output logic [2:0]  status_o
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffa_dpath #(
    .HEAP_BYTES (HEAP_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .opcode_i         (opcode_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_address_o (result_address_o),
    .status_o         (status_o)
  );

endmodule

// ----- design/ffa_checker.sv -----
// Port-level checker of the allocator and its binding to the top level.
`include "first_fit_free_list_allocator_assert.svh"

module ffa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [31:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        opcode_i,
  input logic [31:0] request_size_i,
  input logic [31:0] block_address_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_address_o,
  input logic [2:0]  status_o
);

  // Only reused and new results carry an address.
  `FFA_ASSERT(a_addr_zero, clk_i, rst_ni, (out_valid_o && status_o != ffa_pkg::ST_REUSED && status_o != ffa_pkg::ST_NEW) |-> (result_address_o == 32'd0), "address on a non-grant result")

  // One item in flight: no new beat while a result is pending.
  `FFA_NEVER(a_one_item, clk_i, rst_ni, in_ready_o && out_valid_o, "input ready while result pending")

  `FFA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready right after an accepted beat")

  `FFA_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_address_o) && $stable(status_o)), "stalled result beat changed")

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (.*);

// ----- tb/sv/tb_first_fit_free_list_allocator.sv -----
// Self-checking testbench for the first-fit free-list heap allocator.
`timescale 1ns / 1ps

module tb_first_fit_free_list_allocator;

  localparam int unsigned HEAP_SZ  = 1048576;
  localparam int unsigned BLK_MAX  = 64;
  localparam int unsigned HDR      = ffa_pkg::HEADER_BYTES;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam int unsigned WATCHDOG_CYCLES = 20000;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  status;
  } grant_t;

  typedef struct {
    logic        op;
    logic [31:0] size;
    logic [31:0] addr;
    logic        known;
    logic [31:0] exp_addr;
    logic [2:0]  exp_status;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic [31:0] request_size_i = '0;
  logic [31:0] block_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] result_address_o;
  logic [2:0]  status_o;

  first_fit_free_list_allocator i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .opcode_i, .request_size_i, .block_address_i,
    .out_valid_o, .out_ready_i, .result_address_o, .status_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Heap shadow state.
  logic [31:0] kend;
  logic [31:0] blk_off [BLK_MAX];
  logic [31:0] blk_len [BLK_MAX];
  logic        blk_free [BLK_MAX];
  int unsigned blk_cnt;
  int unsigned free_idx [$];
  logic [31:0] bump;

  grant_t      pending_grants [$];
  int unsigned n_errors = 0;
  int unsigned n_grants = 0;
  int unsigned n_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned status_seen [8];

  function automatic logic [31:0] heap_base();
    return (kend + 32'd3) & ~32'd3;
  endfunction

  function automatic grant_t predict_grant(logic op, logic [31:0] size, logic [31:0] addr);
    grant_t g;
    logic [33:0] rsz;
    int unsigned idx;
    int found;
    g = '{addr: '0, status: ffa_pkg::ST_ZERO};
    if (op == OP_ALLOC) begin
      if (size == 0) return g;
      rsz = ({2'b0, size} + 34'd3) & ~34'd3;
      for (int i = 0; i < free_idx.size(); i++) begin
        idx = free_idx[i];
        if ({2'b0, blk_len[idx]} >= rsz) begin
          free_idx.delete(i);
          blk_free[idx] = 1'b0;
          g.addr = heap_base() + blk_off[idx] + HDR;
          g.status = ffa_pkg::ST_REUSED;
          return g;
        end
      end
      if ({2'b0, bump} + HDR + rsz > HEAP_SZ) begin
        g.status = ffa_pkg::ST_OOM;
      end else if (blk_cnt >= BLK_MAX) begin
        g.status = ffa_pkg::ST_FULL;
      end else begin
        blk_off[blk_cnt] = bump;
        blk_len[blk_cnt] = rsz[31:0];
        blk_free[blk_cnt] = 1'b0;
        bump = bump + HDR + rsz[31:0];
        g.addr = heap_base() + blk_off[blk_cnt] + HDR;
        g.status = ffa_pkg::ST_NEW;
        blk_cnt++;
      end
      return g;
    end
    if (addr == 0) begin
      g.status = ffa_pkg::ST_NULL;
      return g;
    end
    found = -1;
    for (int i = 0; i < blk_cnt; i++) begin
      if (found < 0 && heap_base() + blk_off[i] + HDR == addr) found = i;
    end
    if (found < 0 || blk_free[found] || free_idx.size() >= BLK_MAX) begin
      g.status = ffa_pkg::ST_UNKNOWN;
      return g;
    end
    free_idx.push_front(found);
    blk_free[found] = 1'b1;
    g.status = ffa_pkg::ST_FREED;
    return g;
  endfunction

  // Result side: random stalls and compare against the oldest prediction.
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_grants.size() == 0) begin
          $error("unexpected result beat: addr %h status %0d", result_address_o, status_o);
          n_errors++;
        end else begin
          want = pending_grants.pop_front();
          if (result_address_o !== want.addr) begin
            $error("result_address: expected %h, actual %h", want.addr, result_address_o);
            n_errors++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            n_errors++;
          end
          status_seen[want.status]++;
          n_grants++;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_CYCLES) begin
      $display("first_fit_free_list_allocator: mismatch");
      $finish;
    end
  end

  // Valid stays high after an accepted beat until the next beat or an idle gap replaces it.
  task automatic send_op(logic op, logic [31:0] size, logic [31:0] addr);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    request_size_i <= size;
    block_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    pending_grants.push_back(predict_grant(op, size, addr));
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (4 * BLK_MAX + 20) @(posedge clk_i);
  endtask

  task automatic set_kernel_end(logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    kend = v;
  endtask

  // Pick an address that is usually a live or freed payload, sometimes junk.
  function automatic logic [31:0] pick_address();
    int unsigned r;
    r = $urandom_range(99);
    if (blk_cnt != 0 && r < 80)
      return heap_base() + blk_off[$urandom_range(blk_cnt - 1)] + HDR;
    if (r < 85) return 32'h0;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(64, 1);
    if (r < 90) return $urandom_range(20000, 1);
    if (r < 94) return 32'h0;
    return $urandom;
  endfunction

  task automatic run_random(int unsigned count, int unsigned s_pct, int unsigned r_pct);
    logic op;
    sender_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int unsigned n = 0; n < count; n++) begin
      op = ($urandom_range(99) < 45) ? OP_FREE : OP_ALLOC;
      send_op(op, (op == OP_ALLOC) ? pick_size() : $urandom,
              (op == OP_FREE) ? pick_address() : $urandom);
    end
  endtask

  row_t directed [$];

  task automatic add_row(logic op, logic [31:0] size, logic [31:0] addr, logic known,
                         logic [31:0] ea, logic [2:0] es);
    directed.push_back('{op, size, addr, known, ea, es});
  endtask

  initial begin
    grant_t got;
    kend = '0;
    blk_cnt = 0;
    bump = '0;
    foreach (blk_free[i]) blk_free[i] = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Base 0: first payload lands at offset 8.
    add_row(OP_FREE,  32'h0,        32'h0,        1, 32'h0, ffa_pkg::ST_NULL);
    add_row(OP_ALLOC, 32'h0,        32'hFFFF_FFFF, 1, 32'h0, ffa_pkg::ST_ZERO);
    add_row(OP_ALLOC, 32'hFFFF_FFFF, 32'h0,       1, 32'h0, ffa_pkg::ST_OOM);
    add_row(OP_ALLOC, 32'h1,        32'h0,        1, 32'd8, ffa_pkg::ST_NEW);
    add_row(OP_ALLOC, 32'd5,        32'h0,        1, 32'd20, ffa_pkg::ST_NEW);
    add_row(OP_FREE,  32'hFFFF_FFFF, 32'd12,      1, 32'h0, ffa_pkg::ST_UNKNOWN);
    add_row(OP_FREE,  32'h0,        32'd8,        1, 32'h0, ffa_pkg::ST_FREED);
    add_row(OP_FREE,  32'h0,        32'd8,        1, 32'h0, ffa_pkg::ST_UNKNOWN);
    add_row(OP_FREE,  32'h0,        32'd20,       1, 32'h0, ffa_pkg::ST_FREED);
    add_row(OP_ALLOC, 32'd4,        32'h0,        0, 32'h0, ffa_pkg::ST_ZERO);
    add_row(OP_ALLOC, 32'd8,        32'h0,        0, 32'h0, ffa_pkg::ST_ZERO);
    add_row(OP_ALLOC, 32'd3,        32'h0,        0, 32'h0, ffa_pkg::ST_ZERO);
    add_row(OP_ALLOC, HEAP_SZ - 32, 32'h0,        1, 32'h0, ffa_pkg::ST_OOM);
    add_row(OP_FREE,  32'h0,        32'hFFFF_FFFF, 1, 32'h0, ffa_pkg::ST_UNKNOWN);

    set_kernel_end(32'h0);
    foreach (directed[i]) begin
      send_op(directed[i].op, directed[i].size, directed[i].addr);
      if (directed[i].known) begin
        got = pending_grants[$];
        if (got.addr !== directed[i].exp_addr || got.status !== directed[i].exp_status) begin
          $error("directed row %0d: table says %h/%0d, predictor %h/%0d", i,
                 directed[i].exp_addr, directed[i].exp_status, got.addr, got.status);
          n_errors++;
        end
      end
    end
    drain();

    // Move the base after allocations, including a value that wraps when rounded.
    set_kernel_end(32'hFFFF_FFFD);
    run_random(60, 0, 0);
    drain();
    set_kernel_end(32'hFFFF_FFFF);
    run_random(300, 0, 0);
    // Hold off until every result is back, then continue under idling.
    drain();
    set_kernel_end(32'h0010_0001);
    run_random(280, 60, 0);
    drain();
    set_kernel_end($urandom);
    run_random(250, 0, 60);
    drain();
    set_kernel_end(32'h8000_0002);
    run_random(240, 19, 19);
    drain();

    $display("Sent %0d beats, checked %0d results, %0d blocks carved, bump at %0d bytes.",
             n_sent, n_grants, blk_cnt, bump);
    $display("Status counts reused/new/zero/oom/freed/null/unknown/full: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (n_errors == 0 && pending_grants.size() == 0) begin
      $display("first_fit_free_list_allocator: match");
    end else begin
      $display("first_fit_free_list_allocator: mismatch");
    end
    $finish;
  end

endmodule
